// ===== rtl/core/brht_pkg.sv =====
package brht_pkg;

    // field widths
    localparam int POS_W   = 24;
    localparam int DIFF_W  = POS_W + 1;
    localparam int ANG_W   = 16;
    localparam int RANGE_W = 25;
    localparam int THR_W   = 16;

    // cordic datapath, headroom for the cordic gain and the sign
    localparam int GUARD    = 6;
    localparam int CORD_W   = DIFF_W + GUARD + 3;
    localparam int Z_W      = 24;
    localparam int ITER     = 16;
    localparam int CNT_W    = $clog2(ITER);
    localparam int ATAN_IDX = 5;

    // shared multiplier
    localparam int MUL_A_W = CORD_W - 2;
    localparam int MUL_B_W = 22;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int MAG_SHIFT = 28;

    localparam logic [MUL_B_W-1:0]  INV_GAIN   = MUL_B_W'(2547003);
    localparam logic signed [Z_W-1:0] ANGLE_90 = Z_W'(2304000);
    localparam logic [RANGE_W-1:0]  RANGE_MAX  = '1;
    localparam logic [THR_W-1:0]    THR_RESET  = THR_W'(10);

    // angle codes in hundredths of a degree
    localparam logic [ANG_W:0] DEG_180 = (ANG_W+1)'(18000);
    localparam logic [ANG_W:0] DEG_360 = (ANG_W+1)'(36000);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ_N,
        ST_SQ_E,
        ST_SQ_T,
        ST_MOVE,
        ST_ITER,
        ST_FIN,
        ST_MAG,
        ST_DONE
    } t_state;

    // atan(2^-i) in 1/25600 degree, rounded to nearest
    function automatic logic signed [Z_W-1:0] atan_entry(input logic [ATAN_IDX-1:0] idx);
        logic signed [Z_W-1:0] v;
        unique case (idx)
            5'd0:    v = Z_W'(1152000);
            5'd1:    v = Z_W'(680065);
            5'd2:    v = Z_W'(359328);
            5'd3:    v = Z_W'(182400);
            5'd4:    v = Z_W'(91554);
            5'd5:    v = Z_W'(45822);
            5'd6:    v = Z_W'(22916);
            5'd7:    v = Z_W'(11459);
            5'd8:    v = Z_W'(5730);
            5'd9:    v = Z_W'(2865);
            5'd10:   v = Z_W'(1432);
            5'd11:   v = Z_W'(716);
            5'd12:   v = Z_W'(358);
            5'd13:   v = Z_W'(179);
            5'd14:   v = Z_W'(90);
            5'd15:   v = Z_W'(45);
            5'd16:   v = Z_W'(22);
            5'd17:   v = Z_W'(11);
            5'd18:   v = Z_W'(6);
            5'd19:   v = Z_W'(3);
            5'd20:   v = Z_W'(1);
            5'd21:   v = Z_W'(1);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/core/brht_in_if.sv =====
interface brht_in_if;
    logic                                      valid;
    logic                                      ready;
    logic signed [brht_pkg::POS_W-1:0]         leader_north;
    logic signed [brht_pkg::POS_W-1:0]         leader_east;
    logic signed [brht_pkg::POS_W-1:0]         follower_north;
    logic signed [brht_pkg::POS_W-1:0]         follower_east;

    modport source (
        output valid, leader_north, leader_east, follower_north, follower_east,
        input  ready
    );
    modport sink (
        input  valid, leader_north, leader_east, follower_north, follower_east,
        output ready
    );
endinterface

// ===== rtl/core/brht_out_if.sv =====
interface brht_out_if;
    logic                                valid;
    logic                                ready;
    logic [brht_pkg::ANG_W-1:0]          bearing_to_leader;
    logic [brht_pkg::RANGE_W-1:0]        range_to_leader;
    logic [brht_pkg::ANG_W-1:0]          leader_heading;
    logic                                heading_updated;

    modport source (
        output valid, bearing_to_leader, range_to_leader, leader_heading, heading_updated,
        input  ready
    );
    modport sink (
        input  valid, bearing_to_leader, range_to_leader, leader_heading, heading_updated,
        output ready
    );
endinterface

// ===== rtl/core/bearing_range_heading_tracker_unit.sv =====
// channel   | dir | handshake     | beat contents
// ----------+-----+---------------+----------------------------------------------
// i_in      | in  | valid/ready   | leader north/east, follower north/east
// o_out     | out | valid/ready   | bearing, range, leader heading, update flag
// i_cfg_*   | in  | write enable  | move threshold (16 bit)
//
// a beat runs one vectoring pass when the heading is held and two when it is
// recomputed: one shared cordic stage runs 16 steps per vectoring pass and
// one shared 32x22 multiplier does the move squares and the range scaling.
// ready is high only in idle; a finished result sits in the output register
// while the next beat is taken, and the unit waits only if that register is
// still full when the next result is done. reset is synchronous, active low.
module bearing_range_heading_tracker_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    brht_in_if.sink                       i_in,
    brht_out_if.source                    o_out,
    input  logic                          i_cfg_wr_en,
    input  logic [brht_pkg::THR_W-1:0]    i_cfg_wr_data
);

    brht_pkg::t_state r_state, n_state;

    logic [brht_pkg::THR_W-1:0]           r_thr;
    logic signed [brht_pkg::POS_W-1:0]    r_prev_n, r_prev_e;
    logic [brht_pkg::ANG_W-1:0]           r_held;
    logic signed [brht_pkg::DIFF_W-1:0]   r_dn, r_de, r_mn, r_me;
    logic signed [brht_pkg::CORD_W-1:0]   r_x, r_y;
    logic signed [brht_pkg::Z_W-1:0]      r_z;
    logic [brht_pkg::CNT_W-1:0]           r_cnt;
    logic                                 r_pass;
    logic                                 r_vn_neg, r_ve_neg;
    logic [brht_pkg::PROD_W-1:0]          r_prod, r_sum;
    logic                                 r_moved;
    logic [brht_pkg::ANG_W-1:0]           r_bearing;
    logic [brht_pkg::RANGE_W-1:0]         r_range;
    logic                                 r_out_valid;
    logic [brht_pkg::ANG_W-1:0]           r_out_bearing, r_out_heading;
    logic [brht_pkg::RANGE_W-1:0]         r_out_range;
    logic                                 r_out_updated;

    // control decode
    logic                                 in_ready;
    logic                                 out_free;
    logic                                 load_vec;
    logic [brht_pkg::MUL_A_W-1:0]         mul_a;
    logic [brht_pkg::MUL_B_W-1:0]         mul_b;

    // datapath nets
    logic [brht_pkg::DIFF_W-1:0]          abs_mn, abs_me;
    logic                                 big_move;
    logic signed [brht_pkg::DIFF_W-1:0]   vec_n, vec_e;
    logic [brht_pkg::DIFF_W-1:0]          abs_vn, abs_ve;
    logic signed [brht_pkg::CORD_W-1:0]   sh_x, sh_y;
    logic signed [brht_pkg::Z_W-1:0]      atan_i;
    logic signed [brht_pkg::Z_W-1:0]      z_cl;
    logic [brht_pkg::Z_W-1:0]             z_rnd;
    logic [brht_pkg::ANG_W:0]             q_ang, a_raw;
    logic [brht_pkg::ANG_W-1:0]           a_fin;
    logic [brht_pkg::PROD_W-1:0]          mag_rnd;
    logic [brht_pkg::PROD_W-brht_pkg::MAG_SHIFT-1:0] mag_sh;
    logic [brht_pkg::RANGE_W-1:0]         mag_sat;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            brht_pkg::ST_IDLE: if (i_in.valid) n_state = brht_pkg::ST_SQ_N;
            brht_pkg::ST_SQ_N: n_state = brht_pkg::ST_SQ_E;
            brht_pkg::ST_SQ_E: n_state = brht_pkg::ST_SQ_T;
            brht_pkg::ST_SQ_T: n_state = brht_pkg::ST_MOVE;
            brht_pkg::ST_MOVE: n_state = brht_pkg::ST_ITER;
            brht_pkg::ST_ITER: begin
                if (r_cnt == brht_pkg::CNT_W'(brht_pkg::ITER - 1)) n_state = brht_pkg::ST_FIN;
            end
            brht_pkg::ST_FIN:  n_state = r_pass ? brht_pkg::ST_DONE : brht_pkg::ST_MAG;
            brht_pkg::ST_MAG:  n_state = r_moved ? brht_pkg::ST_ITER : brht_pkg::ST_DONE;
            brht_pkg::ST_DONE: if (out_free) n_state = brht_pkg::ST_IDLE;
            default:           n_state = brht_pkg::ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        in_ready = 1'b0;
        load_vec = 1'b0;
        mul_a    = '0;
        mul_b    = '0;
        unique case (r_state)
            brht_pkg::ST_IDLE: in_ready = 1'b1;
            brht_pkg::ST_SQ_N: begin
                mul_a = brht_pkg::MUL_A_W'(abs_mn[brht_pkg::THR_W-1:0]);
                mul_b = brht_pkg::MUL_B_W'(abs_mn[brht_pkg::THR_W-1:0]);
            end
            brht_pkg::ST_SQ_E: begin
                mul_a = brht_pkg::MUL_A_W'(abs_me[brht_pkg::THR_W-1:0]);
                mul_b = brht_pkg::MUL_B_W'(abs_me[brht_pkg::THR_W-1:0]);
            end
            brht_pkg::ST_SQ_T: begin
                mul_a = brht_pkg::MUL_A_W'(r_thr);
                mul_b = brht_pkg::MUL_B_W'(r_thr);
            end
            brht_pkg::ST_MOVE: load_vec = 1'b1;
            brht_pkg::ST_FIN: begin
                mul_a = r_x[brht_pkg::MUL_A_W-1:0];
                mul_b = brht_pkg::INV_GAIN;
            end
            brht_pkg::ST_MAG:  load_vec = r_moved;
            default: ;
        endcase
    end

    assign out_free = !r_out_valid || o_out.ready;

    // leader move magnitude per axis
    assign abs_mn   = r_mn[brht_pkg::DIFF_W-1] ? brht_pkg::DIFF_W'(-r_mn) : brht_pkg::DIFF_W'(r_mn);
    assign abs_me   = r_me[brht_pkg::DIFF_W-1] ? brht_pkg::DIFF_W'(-r_me) : brht_pkg::DIFF_W'(r_me);
    assign big_move = (abs_mn > brht_pkg::DIFF_W'(r_thr)) || (abs_me > brht_pkg::DIFF_W'(r_thr));

    // vector source for the next cordic pass
    assign vec_n  = (r_state == brht_pkg::ST_MOVE) ? r_dn : r_mn;
    assign vec_e  = (r_state == brht_pkg::ST_MOVE) ? r_de : r_me;
    assign abs_vn = vec_n[brht_pkg::DIFF_W-1] ? brht_pkg::DIFF_W'(-vec_n) : brht_pkg::DIFF_W'(vec_n);
    assign abs_ve = vec_e[brht_pkg::DIFF_W-1] ? brht_pkg::DIFF_W'(-vec_e) : brht_pkg::DIFF_W'(vec_e);

    // shared cordic stage
    assign sh_x   = r_x >>> r_cnt;
    assign sh_y   = r_y >>> r_cnt;
    assign atan_i = brht_pkg::atan_entry(brht_pkg::ATAN_IDX'(r_cnt));

    // angle clamp, rounding and quadrant mapping
    always_comb begin
        if (r_z < 0) begin
            z_cl = '0;
        end else if (r_z > brht_pkg::ANGLE_90) begin
            z_cl = brht_pkg::ANGLE_90;
        end else begin
            z_cl = r_z;
        end
        z_rnd = brht_pkg::Z_W'(z_cl) + brht_pkg::Z_W'(128);
        q_ang = (brht_pkg::ANG_W+1)'(z_rnd >> 8);
        priority if (!r_vn_neg && !r_ve_neg) begin
            a_raw = q_ang;
        end else if (r_vn_neg && !r_ve_neg) begin
            a_raw = brht_pkg::DEG_180 - q_ang;
        end else if (r_vn_neg) begin
            a_raw = brht_pkg::DEG_180 + q_ang;
        end else begin
            a_raw = brht_pkg::DEG_360 - q_ang;
        end
        if (a_raw >= brht_pkg::DEG_360) begin
            a_fin = brht_pkg::ANG_W'(a_raw - brht_pkg::DEG_360);
        end else begin
            a_fin = brht_pkg::ANG_W'(a_raw);
        end
    end

    // range scaling and saturation
    assign mag_rnd = r_prod + (brht_pkg::PROD_W'(1) << (brht_pkg::MAG_SHIFT - 1));
    assign mag_sh  = mag_rnd[brht_pkg::PROD_W-1:brht_pkg::MAG_SHIFT];
    assign mag_sat = (mag_sh > (brht_pkg::PROD_W-brht_pkg::MAG_SHIFT)'(brht_pkg::RANGE_MAX))
                     ? brht_pkg::RANGE_MAX : brht_pkg::RANGE_W'(mag_sh);

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= brht_pkg::ST_IDLE;
            r_thr       <= brht_pkg::THR_RESET;
            r_prev_n    <= '0;
            r_prev_e    <= '0;
            r_held      <= '0;
            r_pass      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) r_thr <= i_cfg_wr_data;
            if (in_ready && i_in.valid) begin
                r_prev_n <= i_in.leader_north;
                r_prev_e <= i_in.leader_east;
            end
            if (r_state == brht_pkg::ST_MOVE) r_pass <= 1'b0;
            if (r_state == brht_pkg::ST_MAG)  r_pass <= 1'b1;
            if (r_state == brht_pkg::ST_FIN && r_pass) r_held <= a_fin;
            if (r_state == brht_pkg::ST_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;

        // capture differences on the input beat
        if (in_ready && i_in.valid) begin
            r_dn <= brht_pkg::DIFF_W'(i_in.leader_north) - brht_pkg::DIFF_W'(i_in.follower_north);
            r_de <= brht_pkg::DIFF_W'(i_in.leader_east) - brht_pkg::DIFF_W'(i_in.follower_east);
            r_mn <= brht_pkg::DIFF_W'(i_in.leader_north) - brht_pkg::DIFF_W'(r_prev_n);
            r_me <= brht_pkg::DIFF_W'(i_in.leader_east) - brht_pkg::DIFF_W'(r_prev_e);
        end

        // squared move against squared threshold
        if (r_state == brht_pkg::ST_SQ_E) r_sum <= r_prod;
        if (r_state == brht_pkg::ST_SQ_T) r_sum <= r_sum + r_prod;
        if (r_state == brht_pkg::ST_MOVE) r_moved <= big_move || (r_sum > r_prod);

        // cordic load and iterate
        if (load_vec) begin
            r_x      <= {{(brht_pkg::CORD_W-brht_pkg::DIFF_W-brht_pkg::GUARD){1'b0}},
                         abs_vn, {brht_pkg::GUARD{1'b0}}};
            r_y      <= {{(brht_pkg::CORD_W-brht_pkg::DIFF_W-brht_pkg::GUARD){1'b0}},
                         abs_ve, {brht_pkg::GUARD{1'b0}}};
            r_z      <= '0;
            r_cnt    <= '0;
            r_vn_neg <= vec_n[brht_pkg::DIFF_W-1];
            r_ve_neg <= vec_e[brht_pkg::DIFF_W-1];
        end else if (r_state == brht_pkg::ST_ITER) begin
            if (r_y > 0) begin
                r_x <= r_x + sh_y;
                r_y <= r_y - sh_x;
                r_z <= r_z + atan_i;
            end else begin
                r_x <= r_x - sh_y;
                r_y <= r_y + sh_x;
                r_z <= r_z - atan_i;
            end
            r_cnt <= r_cnt + 1'b1;
        end

        if (r_state == brht_pkg::ST_FIN && !r_pass) r_bearing <= a_fin;
        if (r_state == brht_pkg::ST_MAG) r_range <= mag_sat;

        // output register
        if (r_state == brht_pkg::ST_DONE && out_free) begin
            r_out_bearing <= r_bearing;
            r_out_range   <= r_range;
            r_out_heading <= r_held;
            r_out_updated <= r_moved;
        end
    end

    assign i_in.ready              = in_ready;
    assign o_out.valid             = r_out_valid;
    assign o_out.bearing_to_leader = r_out_bearing;
    assign o_out.range_to_leader   = r_out_range;
    assign o_out.leader_heading    = r_out_heading;
    assign o_out.heading_updated   = r_out_updated;

endmodule
